@@ rtl/core/quaternion_to_euler_defines.svh @@
// Assertion macros used by quaternion_to_euler. They expect clk and arst_n in scope.
`ifndef QUATERNION_TO_EULER_DEFINES_SVH
`define QUATERNION_TO_EULER_DEFINES_SVH
`ifndef SYNTHESIS
`define QTE_ASSERT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
	else $error("quaternion_to_euler: same-cycle check failed");
`define QTE_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("quaternion_to_euler: next-cycle check failed");
`else
`define QTE_ASSERT(lbl, pre, post)
`define QTE_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ rtl/core/qte_pkg.sv @@
package qte_pkg;

	localparam int QW        = 16;
	localparam int PROD_W    = 32;
	localparam int SUM_W     = 35;
	localparam int S_W       = 32;
	localparam int WORK_BITS = 30;
	localparam int SQ_W      = 62;
	localparam int ROOT_W    = WORK_BITS + 1;
	localparam int NSTEP     = WORK_BITS + 1;
	localparam int CX_W      = 37;
	localparam int ACC_W     = 25;
	localparam int ANG_W     = 16;
	localparam int PITCH_W   = 15;
	localparam int ANG_LIM   = 23040;
	localparam int PITCH_LIM = 11520;

	localparam logic signed [ACC_W-1:0] QUARTER    = ACC_W'(90 * 32768);
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(128);
	localparam logic signed [S_W-1:0]   WONE       = S_W'(64'sd1 <<< WORK_BITS);

	typedef struct packed {
		logic signed [SUM_W-1:0] rn;
		logic signed [SUM_W-1:0] rd;
		logic signed [SUM_W-1:0] yn;
		logic signed [SUM_W-1:0] yd;
		logic signed [S_W-1:0]   s;
		logic                    flag;
	} qte_side_t;

	// atan(2^-i) in 2^-15 degree units.
	function automatic logic signed [ACC_W-1:0] atan_entry(input int i);
		logic signed [ACC_W-1:0] r;
		case (i)
			0: r = ACC_W'(1474560);
			1: r = ACC_W'(870484);
			2: r = ACC_W'(459940);
			3: r = ACC_W'(233473);
			4: r = ACC_W'(117189);
			5: r = ACC_W'(58652);
			6: r = ACC_W'(29333);
			7: r = ACC_W'(14667);
			8: r = ACC_W'(7334);
			9: r = ACC_W'(3667);
			10: r = ACC_W'(1833);
			11: r = ACC_W'(917);
			12: r = ACC_W'(458);
			13: r = ACC_W'(229);
			14: r = ACC_W'(115);
			15: r = ACC_W'(57);
			16: r = ACC_W'(29);
			17: r = ACC_W'(14);
			18: r = ACC_W'(7);
			19: r = ACC_W'(4);
			20: r = ACC_W'(2);
			21: r = ACC_W'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/qte_front.sv @@
module qte_front import qte_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 v_in,
	input  logic signed [QW-1:0] w,
	input  logic signed [QW-1:0] x,
	input  logic signed [QW-1:0] y,
	input  logic signed [QW-1:0] z,
	output logic                 v_out,
	output qte_side_t            side_out,
	output logic [SQ_W-1:0]      n_out
);

	localparam int SH  = 2 * FRAC_BITS - WORK_BITS;
	localparam int SHR = (SH > 0) ? SH : 0;
	localparam int SHL = (SH < 0) ? -SH : 0;
	localparam logic signed [63:0] ONE   = 64'sd1 <<< (2 * FRAC_BITS);
	localparam logic [SQ_W-1:0]    NFULL = SQ_W'(1) << (2 * WORK_BITS);

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [PROD_W-1:0] ww_s1, xx_s1, yy_s1, zz_s1, yz_s1, xw_s1;
	logic signed [PROD_W-1:0] xy_s1, zw_s1, xz_s1, yw_s1;
	logic signed [SUM_W-1:0] rn_s2, rd_s2, yn_s2, yd_s2, sr_s2;
	qte_side_t side_s3, side_s4;
	logic [SQ_W-1:0] n_s4;

	logic signed [63:0] s64, sc;
	logic [63:0] mag, mag2;
	logic neg, flag_c;
	logic signed [S_W-1:0] sw_c;
	logic signed [63:0] sq_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= w * w;
			xx_s1 <= x * x;
			yy_s1 <= y * y;
			zz_s1 <= z * z;
			yz_s1 <= y * z;
			xw_s1 <= x * w;
			xy_s1 <= x * y;
			zw_s1 <= z * w;
			xz_s1 <= x * z;
			yw_s1 <= y * w;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rn_s2 <= (SUM_W'(yz_s1) + SUM_W'(xw_s1)) <<< 1;
			yn_s2 <= (SUM_W'(xy_s1) + SUM_W'(zw_s1)) <<< 1;
			sr_s2 <= (SUM_W'(yw_s1) - SUM_W'(xz_s1)) <<< 1;
			rd_s2 <= SUM_W'(ww_s1) - SUM_W'(xx_s1) - SUM_W'(yy_s1) + SUM_W'(zz_s1);
			yd_s2 <= SUM_W'(ww_s1) + SUM_W'(xx_s1) - SUM_W'(yy_s1) - SUM_W'(zz_s1);
		end
	end

	// Clamp to +-1.0, then rescale the magnitude so the shift rounds toward zero.
	always_comb begin
		s64    = 64'(sr_s2);
		flag_c = (s64 > ONE) || (s64 < -ONE);
		if (s64 > ONE) begin
			sc = ONE;
		end else if (s64 < -ONE) begin
			sc = -ONE;
		end else begin
			sc = s64;
		end
		neg  = sc < 0;
		mag  = neg ? 64'(-sc) : 64'(sc);
		mag2 = (mag >> SHR) << SHL;
		sw_c = neg ? -$signed(mag2[S_W-1:0]) : $signed(mag2[S_W-1:0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.rn   <= rn_s2;
			side_s3.rd   <= rd_s2;
			side_s3.yn   <= yn_s2;
			side_s3.yd   <= yd_s2;
			side_s3.s    <= sw_c;
			side_s3.flag <= flag_c;
		end
	end

	assign sq_c = 64'(side_s3.s) * 64'(side_s3.s);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			n_s4    <= NFULL - sq_c[SQ_W-1:0];
		end
	end

	assign v_out    = v_s4;
	assign side_out = side_s4;
	assign n_out    = n_s4;

endmodule

@@ rtl/core/qte_isqrt.sv @@
module qte_isqrt import qte_pkg::*; #(
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              v_in,
	input  logic [SQ_W-1:0]   n_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              v_out,
	output logic [ROOT_W-1:0] root_out,
	output logic [SIDE_W-1:0] side_out
);

	// One result bit per stage, from the top bit pair down.
	logic              v_s [0:NSTEP-1];
	logic [SQ_W-1:0]   n_s [0:NSTEP-1];
	logic [SQ_W-1:0]   r_s [0:NSTEP-1];
	logic [SIDE_W-1:0] d_s [0:NSTEP-1];

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (WORK_BITS - k));
		logic              vi;
		logic [SQ_W-1:0]   ni, ri, trial;
		logic [SIDE_W-1:0] di;

		if (k == 0) begin : g_first
			assign vi = v_in;
			assign ni = n_in;
			assign ri = '0;
			assign di = side_in;
		end else begin : g_next
			assign vi = v_s[k-1];
			assign ni = n_s[k-1];
			assign ri = r_s[k-1];
			assign di = d_s[k-1];
		end

		assign trial = ri + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k] <= di;
				if (ni >= trial) begin
					n_s[k] <= ni - trial;
					r_s[k] <= (ri >> 1) + BIT;
				end else begin
					n_s[k] <= ni;
					r_s[k] <= ri >> 1;
				end
			end
		end
	end

	assign v_out    = v_s[NSTEP-1];
	assign root_out = r_s[NSTEP-1][ROOT_W-1:0];
	assign side_out = d_s[NSTEP-1];

endmodule

@@ rtl/core/qte_cordic.sv @@
module qte_cordic import qte_pkg::*; #(
	parameter int STAGES = 16,
	parameter int OUT_W  = 16,
	parameter int LIMIT  = 23040
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    v_in,
	input  logic signed [CX_W-1:0]  x_in,
	input  logic signed [CX_W-1:0]  y_in,
	output logic                    v_out,
	output logic signed [OUT_W-1:0] angle
);

	localparam logic signed [ACC_W-1:0] LIM = ACC_W'(LIMIT);

	logic                   v_s1, z_s1;
	logic signed [CX_W-1:0] x_s1, y_s1;
	logic signed [ACC_W-1:0] a_s1;
	logic signed [CX_W-1:0] xp, yp;
	logic signed [ACC_W-1:0] ap;

	logic                    v_s [0:STAGES-1];
	logic                    z_s [0:STAGES-1];
	logic signed [CX_W-1:0]  x_s [0:STAGES-1];
	logic signed [CX_W-1:0]  y_s [0:STAGES-1];
	logic signed [ACC_W-1:0] a_s [0:STAGES-1];

	logic signed [ACC_W-1:0] rr, rs;
	logic                    v_q;
	logic signed [OUT_W-1:0] angle_q;

	// A vector in the left half plane is first turned by a quarter turn.
	always_comb begin
		if (x_in < 0) begin
			if (y_in >= 0) begin
				xp = y_in;
				yp = -x_in;
				ap = QUARTER;
			end else begin
				xp = -y_in;
				yp = x_in;
				ap = -QUARTER;
			end
		end else begin
			xp = x_in;
			yp = y_in;
			ap = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= xp;
			y_s1 <= yp;
			a_s1 <= ap;
			z_s1 <= (x_in == 0) && (y_in == 0);
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		logic                    vi, zi;
		logic signed [CX_W-1:0]  xi, yi;
		logic signed [ACC_W-1:0] ai;

		if (i == 0) begin : g_first
			assign vi = v_s1;
			assign zi = z_s1;
			assign xi = x_s1;
			assign yi = y_s1;
			assign ai = a_s1;
		end else begin : g_next
			assign vi = v_s[i-1];
			assign zi = z_s[i-1];
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign ai = a_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				z_s[i] <= zi;
				if (yi >= 0) begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					a_s[i] <= ai + atan_entry(i);
				end else begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					a_s[i] <= ai - atan_entry(i);
				end
			end
		end
	end

	// Round half up to 1/128 degree and saturate; a null vector gives zero.
	always_comb begin
		rr = (a_s[STAGES-1] + ROUND_HALF) >>> 8;
		if (z_s[STAGES-1]) begin
			rs = '0;
		end else if (rr > LIM) begin
			rs = LIM;
		end else if (rr < -LIM) begin
			rs = -LIM;
		end else begin
			rs = rr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_s[STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= rs[OUT_W-1:0];
		end
	end

	assign v_out = v_q;
	assign angle = angle_q;

endmodule

@@ rtl/core/quaternion_to_euler.sv @@
// Quaternion to Euler angles (x-y-z order). Takes one quaternion per cycle
// while not stalled and gives roll, pitch and yaw in 1/128 degree. The
// pipeline is a front end of products, sums, asin argument clamping and one
// minus the squared argument, a one-bit-per-stage square root that forms the
// cosine of pitch, then three vectoring CORDICs side by side with a
// pre-rotation stage and a rounding stage. The whole pipeline holds while a
// finished result is stalled, so quat_stall follows angle_valid and
// angle_stall. pitch_clamped marks an asin argument beyond +-1.0.
`include "quaternion_to_euler_defines.svh"

module quaternion_to_euler import qte_pkg::*; #(
	parameter int FRAC_BITS     = 14,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      quat_valid,
	output logic                      quat_stall,
	input  logic signed [QW-1:0]      quat_w,
	input  logic signed [QW-1:0]      quat_x,
	input  logic signed [QW-1:0]      quat_y,
	input  logic signed [QW-1:0]      quat_z,
	output logic                      angle_valid,
	input  logic                      angle_stall,
	output logic signed [ANG_W-1:0]   roll_angle,
	output logic signed [PITCH_W-1:0] pitch_angle,
	output logic signed [ANG_W-1:0]   yaw_angle,
	output logic                      pitch_clamped
);

	localparam int SIDE_W = $bits(qte_side_t);
	localparam int FLAG_D = CORDIC_STAGES + 2;

	logic en;
	logic front_v, sq_v, roll_v, pitch_v, yaw_v;
	qte_side_t front_side, sq_side;
	logic [SIDE_W-1:0] sq_side_vec;
	logic [SQ_W-1:0] front_n;
	logic [ROOT_W-1:0] root;
	logic flag_q [0:FLAG_D-1];

	assign en         = !(angle_valid && angle_stall);
	assign quat_stall = !en;

	qte_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (quat_valid),
		.w        (quat_w),
		.x        (quat_x),
		.y        (quat_y),
		.z        (quat_z),
		.v_out    (front_v),
		.side_out (front_side),
		.n_out    (front_n)
	);

	qte_isqrt #(.SIDE_W(SIDE_W)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (front_v),
		.n_in     (front_n),
		.side_in  (front_side),
		.v_out    (sq_v),
		.root_out (root),
		.side_out (sq_side_vec)
	);

	assign sq_side = qte_side_t'(sq_side_vec);

	qte_cordic #(.STAGES(CORDIC_STAGES), .OUT_W(ANG_W), .LIMIT(ANG_LIM)) u_roll (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (sq_v),
		.x_in   (CX_W'(sq_side.rd)),
		.y_in   (CX_W'(sq_side.rn)),
		.v_out  (roll_v),
		.angle  (roll_angle)
	);

	qte_cordic #(.STAGES(CORDIC_STAGES), .OUT_W(PITCH_W), .LIMIT(PITCH_LIM)) u_pitch (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (sq_v),
		.x_in   (CX_W'($signed({1'b0, root}))),
		.y_in   (CX_W'(sq_side.s)),
		.v_out  (pitch_v),
		.angle  (pitch_angle)
	);

	qte_cordic #(.STAGES(CORDIC_STAGES), .OUT_W(ANG_W), .LIMIT(ANG_LIM)) u_yaw (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (sq_v),
		.x_in   (CX_W'(sq_side.yd)),
		.y_in   (CX_W'(sq_side.yn)),
		.v_out  (yaw_v),
		.angle  (yaw_angle)
	);

	// The clamp flag rides alongside the CORDIC lanes.
	always_ff @(posedge clk) begin
		if (en) begin
			flag_q[0] <= sq_side.flag;
			for (int i = 1; i < FLAG_D; i++) begin
				flag_q[i] <= flag_q[i-1];
			end
		end
	end

	assign angle_valid   = roll_v;
	assign pitch_clamped = flag_q[FLAG_D-1];

	`QTE_ASSERT(a_lanes, roll_v || pitch_v || yaw_v, roll_v && pitch_v && yaw_v)
	`QTE_ASSERT(a_s_range, front_v, (front_side.s <= WONE) && (front_side.s >= -WONE))
	`QTE_ASSERT(a_flag_full, front_v && front_side.flag, (front_side.s == WONE) || (front_side.s == -WONE))
	`QTE_ASSERT_NEXT(a_frozen, quat_stall, $stable(front_v) && $stable(roll_angle))

endmodule
